// File: design/i2cms_pkg.sv
// Package for the I2C master transaction sequencer.
// Holds the transaction types, action and status codes and the phase encoding.
// No dependencies.
`default_nettype none

package i2cms_pkg;

  localparam int unsigned AddrWidth  = 7;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned PhaseCount = 7;

  localparam logic [ByteWidth-1:0] StatusMask      = 8'hF8;
  localparam logic [ByteWidth-1:0] StStartSent     = 8'h08;
  localparam logic [ByteWidth-1:0] StRepStartSent  = 8'h10;
  localparam logic [ByteWidth-1:0] StAddrWrAck     = 8'h18;
  localparam logic [ByteWidth-1:0] StDataWrAck     = 8'h28;
  localparam logic [ByteWidth-1:0] StAddrRdAck     = 8'h40;
  localparam logic [ByteWidth-1:0] StDataRdAck     = 8'h50;
  localparam logic [ByteWidth-1:0] StDataRdNack    = 8'h58;

  typedef enum logic [0:0] {
    CMD_BEGIN  = 1'b0,
    CMD_STATUS = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_START = 3'd1,
    ACT_TX    = 3'd2,
    ACT_ACK   = 3'd3,
    ACT_NACK  = 3'd4,
    ACT_STOP  = 3'd5
  } action_t;

  typedef enum logic [PhaseCount-1:0] {
    PH_IDLE   = 7'b0000001,
    PH_WSTART = 7'b0000010,
    PH_WADDR  = 7'b0000100,
    PH_WDATA  = 7'b0001000,
    PH_RSTART = 7'b0010000,
    PH_RADDR  = 7'b0100000,
    PH_RDATA  = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [0:0]           cmd;
    logic [AddrWidth-1:0] target_address;
    logic [ByteWidth-1:0] send_length;
    logic [ByteWidth-1:0] receive_length;
    logic [ByteWidth-1:0] status_code;
    logic [ByteWidth-1:0] bus_read_byte;
    logic [ByteWidth-1:0] next_send_byte;
  } req_item_t;

  typedef struct packed {
    action_t              action;
    logic [ByteWidth-1:0] transmit_byte;
    logic                 received_valid;
    logic [ByteWidth-1:0] received_byte;
    logic                 done_res;
    logic                 failed;
    logic [ByteWidth-1:0] received_total;
  } rsp_item_t;

  typedef struct packed {
    phase_t               phase;
    logic [AddrWidth-1:0] saved_address;
    logic [ByteWidth-1:0] writes_left;
    logic [ByteWidth-1:0] reads_left;
    logic [ByteWidth-1:0] reads_done;
  } seq_state_t;

endpackage

`default_nettype wire

// File: design/i2cms_chan_if.sv
// Valid/ready channel interface carrying one transaction payload.
// Payload type is a parameter; used with the types of i2cms_pkg.
`default_nettype none

interface i2cms_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/i2cms_step.sv
// Next-state and result logic of the I2C transaction sequencer.
// Combinational; uses i2cms_pkg types and status codes.
`default_nettype none

module i2cms_step
  import i2cms_pkg::*;
(
  input  wire seq_state_t cur,
  input  wire req_item_t  req,
  output seq_state_t      nxt,
  output rsp_item_t       rsp
);

  logic [ByteWidth-1:0] status;
  logic                 start_ok;
  logic [ByteWidth-1:0] writes_dec;
  logic [ByteWidth-1:0] reads_dec;
  logic [ByteWidth-1:0] reads_inc;
  action_t              read_req;

  assign status     = req.status_code & StatusMask;
  assign start_ok   = (status == StStartSent) || (status == StRepStartSent);
  assign writes_dec = (cur.writes_left != '0) ? cur.writes_left - 1'b1 : cur.writes_left;
  assign reads_dec  = (cur.reads_left != '0) ? cur.reads_left - 1'b1 : cur.reads_left;
  assign reads_inc  = cur.reads_done + 1'b1;
  assign read_req   = (cur.reads_left == ByteWidth'(1)) ? ACT_NACK : ACT_ACK;

  always_comb begin
    nxt = cur;
    rsp = '0;
    rsp.action = ACT_NONE;
    if (req.cmd == CMD_BEGIN) begin
      nxt.saved_address = req.target_address;
      nxt.writes_left   = req.send_length;
      nxt.reads_left    = req.receive_length;
      nxt.reads_done    = '0;
      if (req.send_length != '0) begin
        rsp.action = ACT_START;
        nxt.phase  = PH_WSTART;
      end else if (req.receive_length != '0) begin
        rsp.action = ACT_START;
        nxt.phase  = PH_RSTART;
      end else begin
        rsp.action   = ACT_STOP;
        rsp.done_res = 1'b1;
        nxt.phase    = PH_IDLE;
      end
    end else begin
      unique case (cur.phase)
        PH_IDLE: begin
          nxt.phase = PH_IDLE;
        end
        PH_WSTART: begin
          if (start_ok) begin
            rsp.action        = ACT_TX;
            rsp.transmit_byte = {cur.saved_address, 1'b0};
            nxt.phase         = PH_WADDR;
          end else begin
            rsp.action   = ACT_STOP;
            rsp.done_res = 1'b1;
            rsp.failed   = 1'b1;
            nxt.phase    = PH_IDLE;
          end
        end
        PH_WADDR: begin
          if (status == StAddrWrAck) begin
            rsp.action        = ACT_TX;
            rsp.transmit_byte = req.next_send_byte;
            nxt.phase         = PH_WDATA;
          end else begin
            rsp.action   = ACT_STOP;
            rsp.done_res = 1'b1;
            rsp.failed   = 1'b1;
            nxt.phase    = PH_IDLE;
          end
        end
        PH_WDATA: begin
          if (status == StDataWrAck) begin
            nxt.writes_left = writes_dec;
            if (writes_dec != '0) begin
              rsp.action        = ACT_TX;
              rsp.transmit_byte = req.next_send_byte;
            end else if (cur.reads_left != '0) begin
              rsp.action = ACT_START;
              nxt.phase  = PH_RSTART;
            end else begin
              rsp.action         = ACT_STOP;
              rsp.done_res       = 1'b1;
              rsp.received_total = cur.reads_done;
              nxt.phase          = PH_IDLE;
            end
          end else begin
            rsp.action   = ACT_STOP;
            rsp.done_res = 1'b1;
            rsp.failed   = 1'b1;
            nxt.phase    = PH_IDLE;
          end
        end
        PH_RSTART: begin
          if (start_ok) begin
            rsp.action        = ACT_TX;
            rsp.transmit_byte = {cur.saved_address, 1'b1};
            nxt.phase         = PH_RADDR;
          end else begin
            rsp.action   = ACT_STOP;
            rsp.done_res = 1'b1;
            rsp.failed   = 1'b1;
            nxt.phase    = PH_IDLE;
          end
        end
        PH_RADDR: begin
          if (status == StAddrRdAck) begin
            rsp.action = read_req;
            nxt.phase  = PH_RDATA;
          end else begin
            rsp.action   = ACT_STOP;
            rsp.done_res = 1'b1;
            rsp.failed   = 1'b1;
            nxt.phase    = PH_IDLE;
          end
        end
        PH_RDATA: begin
          if ((status == StDataRdAck) || (status == StDataRdNack)) begin
            rsp.received_valid = 1'b1;
            rsp.received_byte  = req.bus_read_byte;
            nxt.reads_done     = reads_inc;
            nxt.reads_left     = reads_dec;
            if (reads_dec != '0) begin
              rsp.action = (reads_dec == ByteWidth'(1)) ? ACT_NACK : ACT_ACK;
            end else begin
              rsp.action         = ACT_STOP;
              rsp.done_res       = 1'b1;
              rsp.received_total = reads_inc;
              nxt.phase          = PH_IDLE;
            end
          end else begin
            rsp.action   = ACT_STOP;
            rsp.done_res = 1'b1;
            rsp.failed   = 1'b1;
            nxt.phase    = PH_IDLE;
          end
        end
        default: begin
          nxt.phase = PH_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/i2cms_out_buf.sv
// Result register with a one-entry skid stage for the sequencer output.
// Uses rsp_item_t from i2cms_pkg.
`default_nettype none

module i2cms_out_buf
  import i2cms_pkg::*;
(
  input  wire            clk,
  input  wire            rst,
  input  wire            push,
  input  wire rsp_item_t push_data,
  output logic           space,
  output logic           out_valid,
  output rsp_item_t      out_data,
  input  wire            out_ready
);

  logic      skid_valid;
  rsp_item_t skid_data;
  logic      pop;

  assign pop   = out_valid && out_ready;
  assign space = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_data  <= push_data;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: design/i2c_master_transaction_sequencer.sv
// Top level of the I2C master write-then-read transaction sequencer.
// Depends on i2cms_pkg, i2cms_chan_if, i2cms_step and i2cms_out_buf.
//
// Usage:
//   req carries one transaction per item: a begin (cmd 0) with address and
//   lengths, or an engine status event (cmd 1) with status and data bytes.
//   rsp carries exactly one result per accepted req transaction: the next
//   engine action, the byte to transmit, any received byte, and on the final
//   stop the done, failed and received-count fields.
//   Results are registered, in the result register or the skid stage.
//   Throughput is one transaction per cycle while req.ready is high, set
//   by the single registered phase machine that updates at every accept.
//   A result register plus a one-entry skid stage decouple the channels:
//   req stays ready while one result waits; when rsp stalls with both
//   entries full, req.ready drops until a result is taken.
//   Synchronous reset returns the phase to idle, clears the counters and
//   empties the output stages.
`default_nettype none

module i2c_master_transaction_sequencer
  import i2cms_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  i2cms_chan_if.sink   req,
  i2cms_chan_if.source rsp
);

  seq_state_t state;
  seq_state_t state_next;
  rsp_item_t  result;
  req_item_t  req_item;
  rsp_item_t  rsp_item;
  logic       accept;
  logic       space;

  assign req_item  = req.data;
  assign req.ready = space;
  assign accept    = req.valid && space;
  assign rsp.data  = rsp_item;

  i2cms_step u_step (
    .cur (state),
    .req (req_item),
    .nxt (state_next),
    .rsp (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase         <= PH_IDLE;
      state.saved_address <= '0;
      state.writes_left   <= '0;
      state.reads_left    <= '0;
      state.reads_done    <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  i2cms_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .space     (space),
    .out_valid (rsp.valid),
    .out_data  (rsp_item),
    .out_ready (rsp.ready)
  );

endmodule

`default_nettype wire
